[hdl/srp_pkg.sv]
package srp_pkg;

   localparam int unsigned SIDE_W = 13;
   localparam int unsigned PAD_W  = 8;
   localparam int unsigned CALC_W = 16;

   typedef enum logic {
      OP_PLACE   = 1'b0,
      OP_RESTART = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_TOO_LARGE     = 2'd1,
      STATUS_OUT_OF_HEIGHT = 2'd2,
      STATUS_REJECTED      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_ATLAS_WIDTH = 2'd0,
      CSR_MAX_HEIGHT  = 2'd1,
      CSR_PADDING     = 2'd2
   } csr_index_type;

   localparam logic [SIDE_W-1:0] ATLAS_WIDTH_RESET = 13'd4096;
   localparam logic [SIDE_W-1:0] MAX_HEIGHT_RESET  = 13'd4096;
   localparam logic [PAD_W-1:0]  PADDING_RESET     = 8'd0;

   typedef struct packed {
      op_type            op;
      logic [SIDE_W-1:0] rect_width;
      logic [SIDE_W-1:0] rect_height;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SIDE_W-1:0] region_x;
      logic [SIDE_W-1:0] region_y;
      logic [SIDE_W-1:0] packed_height;
      logic [SIDE_W-1:0] pow2_height;
      logic              height_fits;
   } rsp_type;

   typedef struct packed {
      logic [SIDE_W-1:0] atlas_width;
      logic [SIDE_W-1:0] max_height;
      logic [PAD_W-1:0]  padding;
   } cfg_type;

   typedef struct packed {
      logic [SIDE_W-1:0] shelf_x;
      logic [SIDE_W-1:0] shelf_y;
      logic [SIDE_W-1:0] shelf_height;
      logic              failed;
   } shelf_type;

   function automatic logic [CALC_W-1:0] round_pow2(input logic [CALC_W-1:0] v);
      logic [CALC_W-1:0] m;
      logic [CALC_W-1:0] p;
      m = v - CALC_W'(1);
      p = CALC_W'(1);
      if (v > CALC_W'(1)) begin
         for (int i = 0; i < CALC_W - 1; i++) begin
            if (m[i]) begin
               p = CALC_W'(1) << (i + 1);
            end
         end
      end
      return p;
   endfunction

endpackage

[hdl/srp_if.sv]
interface srp_req_if;
   logic             valid;
   logic             ready;
   srp_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface srp_rsp_if;
   logic             valid;
   logic             ready;
   srp_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hdl/srp_place.sv]
module srp_place #(
   parameter int unsigned MAX_SIDE = 4096
) (
   input  srp_pkg::cfg_type   cfg,
   input  srp_pkg::shelf_type shelf,
   input  srp_pkg::req_type   req,
   output srp_pkg::shelf_type shelf_next,
   output srp_pkg::rsp_type   rsp
);
   import srp_pkg::*;

   logic [CALC_W-1:0] aw;
   logic [CALC_W-1:0] mh;
   logic [CALC_W-1:0] pad;
   logic [CALC_W-1:0] pw;
   logic [CALC_W-1:0] ph;
   logic [CALC_W-1:0] sx;
   logic [CALC_W-1:0] sy;
   logic [CALC_W-1:0] sh;
   logic [CALC_W-1:0] nx;
   logic [CALC_W-1:0] ny;
   logic [CALC_W-1:0] nh;
   logic [CALC_W-1:0] packed_h;
   logic [CALC_W-1:0] p2;
   logic              too_large;
   logic              wrap;
   logic              over_height;

   always_comb begin
      aw = (32'(cfg.atlas_width) > 32'(MAX_SIDE)) ? CALC_W'(MAX_SIDE)
                                                   : CALC_W'(cfg.atlas_width);
      mh = (32'(cfg.max_height) > 32'(MAX_SIDE)) ? CALC_W'(MAX_SIDE)
                                                  : CALC_W'(cfg.max_height);
      pad = CALC_W'(cfg.padding);
      pw  = CALC_W'(req.rect_width) + (pad << 1);
      ph  = CALC_W'(req.rect_height) + (pad << 1);
      sx  = CALC_W'(shelf.shelf_x);
      sy  = CALC_W'(shelf.shelf_y);
      sh  = CALC_W'(shelf.shelf_height);

      too_large = (pw > aw) || (ph > mh);
      wrap      = (sx + pw) > aw;
      nx        = wrap ? '0 : sx;
      ny        = wrap ? (sy + sh) : sy;
      nh        = wrap ? '0 : sh;
      over_height = (ny + ph) > mh;

      shelf_next = shelf;
      rsp        = '0;
      rsp.status = STATUS_OK;

      priority if (req.op == OP_RESTART) begin
         shelf_next = '0;
      end else if (shelf.failed) begin
         rsp.status = STATUS_REJECTED;
      end else if (too_large) begin
         rsp.status        = STATUS_TOO_LARGE;
         shelf_next.failed = 1'b1;
      end else if (over_height) begin
         rsp.status        = STATUS_OUT_OF_HEIGHT;
         shelf_next.failed = 1'b1;
      end else begin
         rsp.region_x            = SIDE_W'(nx + pad);
         rsp.region_y            = SIDE_W'(ny + pad);
         shelf_next.shelf_x      = SIDE_W'(nx + pw);
         shelf_next.shelf_y      = SIDE_W'(ny);
         shelf_next.shelf_height = SIDE_W'((nh > ph) ? nh : ph);
      end

      packed_h = CALC_W'(shelf_next.shelf_y) + CALC_W'(shelf_next.shelf_height);
      p2       = round_pow2(packed_h);

      rsp.packed_height = SIDE_W'(packed_h);
      rsp.pow2_height   = SIDE_W'(p2);
      rsp.height_fits   = (p2 <= mh);
   end

endmodule

[hdl/shelf_rect_packer.sv]
// Next-fit shelf packer for rectangles.
//
// Requests arrive on req_if (valid/ready): op selects place or restart, with
// the unpadded rectangle width and height. Each request yields exactly one
// response on rsp_if with status, region position, packed height, that
// height rounded up to a power of two and a fit flag.
// Registers are written through csr_write_en/csr_index/csr_wdata: index 0
// atlas width, 1 height limit, 2 padding; write only while no request is
// in flight.
// A request accepted on req_if is registered, placed combinationally and
// its response is registered and offered on rsp_if. Throughput is one
// request per cycle while the receiver does not stall, set by the single
// placement stage between the request and response registers.
// Reset (synchronous, active high) clears the shelf state and failure flag,
// restores register defaults and empties both stages.
// When the receiver stalls the response is held; one more request is taken
// into the request register, then req_if.ready drops until rsp_if drains.
module shelf_rect_packer #(
   parameter int unsigned MAX_SIDE = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   srp_req_if.sink                   req_if,
   srp_rsp_if.source                 rsp_if,
   input  logic                      csr_write_en,
   input  logic [1:0]                csr_index,
   input  logic [srp_pkg::SIDE_W-1:0] csr_wdata
);
   import srp_pkg::*;

   cfg_type   cfg_ff,   cfg_in;
   shelf_type shelf_ff, shelf_in;
   logic      req_valid_ff, req_valid_in;
   req_type   req_data_ff,  req_data_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff,  rsp_data_in;
   shelf_type shelf_next;
   rsp_type   rsp_next;
   logic      advance;

   srp_place #(
      .MAX_SIDE (MAX_SIDE)
   ) u_place (
      .cfg        (cfg_ff),
      .shelf      (shelf_ff),
      .req        (req_data_ff),
      .shelf_next (shelf_next),
      .rsp        (rsp_next)
   );

   assign advance       = req_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !req_valid_ff || advance;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ATLAS_WIDTH: cfg_in.atlas_width = csr_wdata;
            CSR_MAX_HEIGHT:  cfg_in.max_height  = csr_wdata;
            CSR_PADDING:     cfg_in.padding     = csr_wdata[PAD_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      req_valid_in = req_valid_ff;
      req_data_in  = req_data_ff;
      if (req_if.valid && req_if.ready) begin
         req_valid_in = 1'b1;
         req_data_in  = req_if.payload;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end

      shelf_in     = advance ? shelf_next : shelf_ff;
      rsp_data_in  = advance ? rsp_next : rsp_data_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.atlas_width <= ATLAS_WIDTH_RESET;
         cfg_ff.max_height  <= MAX_HEIGHT_RESET;
         cfg_ff.padding     <= PADDING_RESET;
         shelf_ff           <= '0;
         req_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         shelf_ff     <= shelf_in;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
